// ===== hdl/tmf_pkg.sv =====
`timescale 1ns / 1ps

package tmf_pkg;

  localparam int DEFAULT_CAPACITY = 256;

  localparam int TOTAL_W = 9;

  localparam logic [7:0] END_BYTE = 8'hFF;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_HEADER = 2'd1,
    REQ_VALUE  = 2'd2,
    REQ_FINAL  = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_SEALED = 3'd1,
    ST_ORDER  = 3'd2,
    ST_NOROOM = 3'd3,
    ST_SEQ    = 3'd4
  } status_t;

endpackage

// ===== hdl/tmf_req_if.sv =====
`timescale 1ns / 1ps

interface tmf_req_if import tmf_pkg::*; ();
  logic      valid;
  logic      ready;
  req_type_t req_type;
  logic [7:0] entry_tag;
  logic [7:0] value_length;
  logic [7:0] value_byte;

  modport source (output valid, req_type, entry_tag, value_length, value_byte,
                  input ready);
  modport sink (input valid, req_type, entry_tag, value_length, value_byte,
                output ready);
endinterface

// ===== hdl/tmf_rsp_if.sv =====
`timescale 1ns / 1ps

interface tmf_rsp_if import tmf_pkg::*; ();
  logic               valid;
  logic               ready;
  status_t            status;
  logic [1:0]         emit_count;
  logic [7:0]         first_byte;
  logic [7:0]         second_byte;
  logic [TOTAL_W-1:0] total_length;

  modport source (output valid, status, emit_count, first_byte, second_byte,
                  total_length, input ready);
  modport sink (input valid, status, emit_count, first_byte, second_byte,
                total_length, output ready);
endinterface

// ===== hdl/tlv_metadata_framer_core.sv =====
`timescale 1ns / 1ps

// Tag-length-value record framer. Each request (clear, entry header, value
// byte, finalize) yields exactly one response carrying a status, up to two
// emitted bytes and the running record length in its low nine bits. Tags
// must rise strictly, an entry's value bytes must arrive before the next
// header or finalize, and the record never grows past CAPACITY bytes.
// A request is registered on acceptance and its response is formed from
// that register and the record state into the response register when the
// response register is free to advance; one request is taken every cycle
// while the response side keeps up.
// A stalled response holds the request register, which in turn drops ready.
module tlv_metadata_framer_core import tmf_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic      clk,
  input  logic      rst,
  tmf_req_if.sink   req,
  tmf_rsp_if.source rsp
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = $clog2(CAPACITY + 258);

  // Request register.
  logic       in_valid;
  req_type_t  in_type;
  logic [7:0] in_tag;
  logic [7:0] in_len;
  logic [7:0] in_byte;

  // Record state.
  logic [CW-1:0] bytes_used;
  logic [7:0]    previous_tag;
  logic          any_tag_seen;
  logic          sealed;
  logic [7:0]    value_bytes_pending;

  logic [CW-1:0] bytes_used_next;
  logic [7:0]    previous_tag_next;
  logic          any_tag_seen_next;
  logic          sealed_next;
  logic [7:0]    value_bytes_pending_next;

  status_t            status_next;
  logic [1:0]         emit_count_next;
  logic [7:0]         first_byte_next;
  logic [7:0]         second_byte_next;
  logic [TOTAL_W-1:0] total_length_next;

  logic advance;
  logic [SW-1:0] header_end;
  logic [SW-1:0] used_ext;
  logic [SW-1:0] used_next_ext;

  assign advance   = !rsp.valid || rsp.ready;
  assign req.ready = !in_valid || advance;

  assign used_ext      = SW'(bytes_used);
  assign used_next_ext = SW'(bytes_used_next);
  assign header_end    = used_ext + SW'(in_len) + SW'(2);

  always_comb begin
    bytes_used_next          = bytes_used;
    previous_tag_next        = previous_tag;
    any_tag_seen_next        = any_tag_seen;
    sealed_next              = sealed;
    value_bytes_pending_next = value_bytes_pending;
    status_next              = ST_OK;
    emit_count_next          = 2'd0;
    first_byte_next          = 8'd0;
    second_byte_next         = 8'd0;
    total_length_next        = used_ext[TOTAL_W-1:0];
    case (in_type)
      REQ_CLEAR: begin
        bytes_used_next          = '0;
        previous_tag_next        = 8'd0;
        any_tag_seen_next        = 1'b0;
        sealed_next              = 1'b0;
        value_bytes_pending_next = 8'd0;
        total_length_next        = '0;
      end
      REQ_HEADER: begin
        if (value_bytes_pending != 8'd0) begin
          status_next = ST_SEQ;
        end else if (sealed) begin
          status_next = ST_SEALED;
        end else if (any_tag_seen && previous_tag >= in_tag) begin
          status_next = ST_ORDER;
        end else if (header_end > SW'(CAPACITY)) begin
          status_next = ST_NOROOM;
        end else begin
          bytes_used_next          = bytes_used + CW'(2);
          value_bytes_pending_next = in_len;
          previous_tag_next        = in_tag;
          any_tag_seen_next        = 1'b1;
          emit_count_next          = 2'd2;
          first_byte_next          = in_tag;
          second_byte_next         = in_len;
          total_length_next        = used_next_ext[TOTAL_W-1:0];
        end
      end
      REQ_VALUE: begin
        if (value_bytes_pending == 8'd0) begin
          status_next = ST_SEQ;
        end else begin
          bytes_used_next          = bytes_used + CW'(1);
          value_bytes_pending_next = value_bytes_pending - 8'd1;
          emit_count_next          = 2'd1;
          first_byte_next          = in_byte;
          total_length_next        = used_next_ext[TOTAL_W-1:0];
        end
      end
      REQ_FINAL: begin
        if (value_bytes_pending != 8'd0) begin
          status_next = ST_SEQ;
        end else if (sealed) begin
          status_next = ST_OK;
        end else if (bytes_used >= CW'(CAPACITY)) begin
          // A full record reports a zero length with the no-room status.
          status_next       = ST_NOROOM;
          total_length_next = '0;
        end else begin
          bytes_used_next   = bytes_used + CW'(1);
          sealed_next       = 1'b1;
          emit_count_next   = 2'd1;
          first_byte_next   = END_BYTE;
          total_length_next = used_next_ext[TOTAL_W-1:0];
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid            <= 1'b0;
      rsp.valid           <= 1'b0;
      bytes_used          <= '0;
      previous_tag        <= 8'd0;
      any_tag_seen        <= 1'b0;
      sealed              <= 1'b0;
      value_bytes_pending <= 8'd0;
    end else begin
      if (req.ready) begin
        in_valid <= req.valid;
      end
      if (advance) begin
        rsp.valid <= in_valid;
      end
      if (advance && in_valid) begin
        bytes_used          <= bytes_used_next;
        previous_tag        <= previous_tag_next;
        any_tag_seen        <= any_tag_seen_next;
        sealed              <= sealed_next;
        value_bytes_pending <= value_bytes_pending_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      in_type <= req.req_type;
      in_tag  <= req.entry_tag;
      in_len  <= req.value_length;
      in_byte <= req.value_byte;
    end
    if (advance && in_valid) begin
      rsp.status       <= status_next;
      rsp.emit_count   <= emit_count_next;
      rsp.first_byte   <= first_byte_next;
      rsp.second_byte  <= second_byte_next;
      rsp.total_length <= total_length_next;
    end
  end

  // A sealed record can only have been closed with no value bytes owed.
  a_sealed_no_pending: assert property (@(posedge clk) disable iff (rst)
    sealed |-> value_bytes_pending == 8'd0)
    else $error("record sealed with value bytes pending");

  // Reserved value bytes are counted at header time, so the record never
  // exceeds its capacity.
  a_within_capacity: assert property (@(posedge clk) disable iff (rst)
    bytes_used <= CW'(CAPACITY))
    else $error("record length beyond capacity");

  // Two bytes are only emitted by a successful header.
  a_two_bytes_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.emit_count == 2'd2 |-> rsp.status == ST_OK)
    else $error("two bytes emitted on a failed request");

  // Back-pressure only appears when both stages are full and the
  // response is stalled.
  a_ready_low_cause: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> in_valid && rsp.valid && !rsp.ready)
    else $error("request side stalled without a full pipeline");

  // A held request must not change the record state.
  a_state_held: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(bytes_used) && $stable(value_bytes_pending))
    else $error("record state changed during a stall");

endmodule
